>>> sv/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, character codes and helpers of the C string escape encoder.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned MaxChars          = 5;
  localparam int unsigned CountW            = 3;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChBslash   = 8'h5c;
  localparam logic [7:0] ChX        = 8'h78;
  localparam logic [7:0] ChNone     = 8'h00;
  localparam logic [7:0] PrintLow   = 8'h20;
  localparam logic [7:0] PrintHigh  = 8'h7e;
  localparam logic [7:0] DigitBase  = 8'h30;
  localparam logic [7:0] LetterBase = 8'h57;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CountW-1:0]        count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h5c:   r = 8'h5c;
      8'h07:   r = 8'h61;
      8'h08:   r = 8'h62;
      8'h0c:   r = 8'h66;
      8'h0a:   r = 8'h6e;
      8'h0d:   r = 8'h72;
      8'h09:   r = 8'h74;
      8'h0b:   r = 8'h76;
      default: r = ChNone;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = DigitBase + {4'h0, n};
    end else begin
      r = LetterBase + {4'h0, n};
    end
    return r;
  endfunction

endpackage

>>> sv/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Accepts input beats, holds the mode register and string state, and turns
// each beat into a job of up to five characters for the queue.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  cse_pkg::in_beat_t      in_beat_i,
  input  cse_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output cse_pkg::job_t          job_o
);

  logic quoted_q, quoted_d;
  logic open_q, open_d;
  logic accept;
  logic prefix;
  logic [7:0] letter;
  logic [3:0][7:0] body;
  logic [cse_pkg::CountW-1:0] blen;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status_i.full;
  assign accept      = in_valid_i & ~in_stall_o;
  assign letter      = cse_pkg::esc_letter(in_beat_i.data_byte);
  assign prefix      = quoted_q & ~open_q;

  always_comb begin
    body = '0;
    blen = '0;
    if (quoted_q && in_beat_i.data_byte == cse_pkg::ChQuote) begin
      body[0] = cse_pkg::ChBslash;
      body[1] = cse_pkg::ChQuote;
      blen    = cse_pkg::CountW'(2);
    end else if (letter != cse_pkg::ChNone) begin
      body[0] = cse_pkg::ChBslash;
      body[1] = letter;
      blen    = cse_pkg::CountW'(2);
    end else if (in_beat_i.data_byte >= cse_pkg::PrintLow &&
                 in_beat_i.data_byte <= cse_pkg::PrintHigh) begin
      body[0] = in_beat_i.data_byte;
      blen    = cse_pkg::CountW'(1);
    end else begin
      body[0] = cse_pkg::ChBslash;
      body[1] = cse_pkg::ChX;
      body[2] = cse_pkg::hex_char(in_beat_i.data_byte[7:4]);
      body[3] = cse_pkg::hex_char(in_beat_i.data_byte[3:0]);
      blen    = cse_pkg::CountW'(4);
    end
  end

  always_comb begin
    job_o  = '0;
    open_d = open_q;
    if (in_beat_i.kind == cse_pkg::KindData) begin
      if (prefix) begin
        job_o.chars = {body, cse_pkg::ChQuote};
        job_o.count = blen + cse_pkg::CountW'(1);
      end else begin
        job_o.chars = {cse_pkg::ChNone, body};
        job_o.count = blen;
      end
      if (accept && quoted_q) begin
        open_d = 1'b1;
      end
    end else begin
      if (quoted_q) begin
        job_o.chars[0] = cse_pkg::ChQuote;
        job_o.chars[1] = cse_pkg::ChQuote;
        job_o.count    = open_q ? cse_pkg::CountW'(1) : cse_pkg::CountW'(2);
      end
      if (accept) begin
        open_d = 1'b0;
      end
    end
  end

  assign push_o   = accept & (job_o.count != '0);
  assign quoted_d = (cfg_valid_i & cfg_ready_o) ? cfg_data_i : quoted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q <= 1'b1;
      open_q   <= 1'b0;
    end else begin
      quoted_q <= quoted_d;
      open_q   <= open_d;
    end
  end

endmodule

>>> sv/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Front-to-back job queue; one push unless full, one pop unless empty per cycle.
// ----------------------------------------------------------------------------
module cse_queue #(
  parameter int unsigned Depth = cse_pkg::QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cse_pkg::job_t          job_i,
  input  logic                   pop_i,
  output cse_pkg::job_t          head_o,
  output cse_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cse_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Walks head job chars into the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cse_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cse_pkg::job_t          head_i,
  input  cse_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cse_pkg::out_beat_t     out_beat_o
);

  logic [cse_pkg::CountW-1:0] idx_q, idx_d;
  logic valid_q, valid_d;
  cse_pkg::out_beat_t beat_q, beat_d;
  logic load, take, is_last;

  assign load    = ~valid_q | ~out_stall_i;
  assign take    = load & ~q_status_i.empty;
  assign is_last = (idx_q == head_i.count - cse_pkg::CountW'(1));
  assign pop_o   = take & is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load) begin
      valid_d = take;
    end
    if (take) begin
      beat_d.out_char = head_i.chars[idx_q];
      beat_d.last     = is_last;
      idx_d           = is_last ? '0 : idx_q + cse_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

>>> sv/c_string_escape_encoder.sv
// ----------------------------------------------------------------------------
// c_string_escape_encoder
// Streams raw bytes in and C-style escaped text out, one character per beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with in_beat_i (kind, data_byte);
// a beat is taken when valid is high and stall is low. Kind marks a data
// byte or the end of a string.
// Output channel: out_valid_o / out_stall_i with out_beat_o (out_char, last);
// last flags the final character of one input beat.
// Config channel: cfg_valid_i / cfg_ready_o carries quoted_mode; ready is
// always high. Write it only while the block is idle.
// The first character of a beat is offered after it has passed through the
// job queue and the output register. Throughput: one character per cycle
// while out_stall_i is low; a beat expands to one to five characters, and an
// end marker in plain mode to none. The job queue (QueueDepth entries) lets
// input run ahead.
// Reset: quoted_mode is 1, no string is open, queue and output are empty.
// A stalled output holds its character; once the queue fills, in_stall_o
// rises until the back end frees an entry.
// ----------------------------------------------------------------------------
module c_string_escape_encoder #(
  parameter int unsigned QueueDepth = cse_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cse_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cse_pkg::out_beat_t out_beat_o
);

  cse_pkg::job_t          job, head;
  cse_pkg::queue_status_t q_status;
  logic                   push, pop;

  cse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  cse_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(q_status)
  );

  cse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("job popped from empty queue");

  a_data_makes_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_beat_i.kind == cse_pkg::KindData) |-> push)
    else $error("data beat produced no job");

endmodule

>>> test/tb_c_string_escape_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_string_escape_encoder
// Self-checking bench for the C string escape encoder: directed and random
// byte streams in both quoting modes, random idling on both channels and a
// long output hold-off. Each output beat is compared against a behavioral
// escape predictor.
// ----------------------------------------------------------------------------
module tb_c_string_escape_encoder;

  localparam int unsigned SettleCycles = 24;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems   = 40;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_data   = 1'b0;
  logic               cfg_ready_o;
  logic               in_valid   = 1'b0;
  cse_pkg::in_beat_t  in_beat    = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall  = 1'b0;
  cse_pkg::out_beat_t out_beat_o;

  logic               quoted_mode_q = 1'b1;
  logic               string_open_q = 1'b0;
  cse_pkg::out_beat_t expected_chars [$];
  int unsigned        mismatches    = 0;
  int unsigned        quiet_cycles  = 0;
  int unsigned        rx_hold_cycles = 0;
  bit                 tx_idle_on    = 1'b1;
  bit                 rx_idle_on    = 1'b1;

  c_string_escape_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] escape_letter_of(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      cse_pkg::ChBslash: r = cse_pkg::ChBslash;
      8'h07:             r = "a";
      8'h08:             r = "b";
      8'h0c:             r = "f";
      8'h0a:             r = "n";
      8'h0d:             r = "r";
      8'h09:             r = "t";
      8'h0b:             r = "v";
      default:           r = cse_pkg::ChNone;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = "0" + {4'h0, n};
    end else begin
      r = "a" + {4'h0, n} - 8'd10;
    end
    return r;
  endfunction

  task automatic predict_escape(input cse_pkg::in_beat_t beat);
    logic [7:0]         chars [$];
    logic [7:0]         letter;
    cse_pkg::out_beat_t res;
    if (beat.kind == cse_pkg::KindData) begin
      if (quoted_mode_q && !string_open_q) begin
        chars.push_back(cse_pkg::ChQuote);
        string_open_q = 1'b1;
      end
      letter = escape_letter_of(beat.data_byte);
      if (quoted_mode_q && beat.data_byte == cse_pkg::ChQuote) begin
        chars.push_back(cse_pkg::ChBslash);
        chars.push_back(cse_pkg::ChQuote);
      end else if (letter != cse_pkg::ChNone) begin
        chars.push_back(cse_pkg::ChBslash);
        chars.push_back(letter);
      end else if (beat.data_byte >= cse_pkg::PrintLow &&
                   beat.data_byte <= cse_pkg::PrintHigh) begin
        chars.push_back(beat.data_byte);
      end else begin
        chars.push_back(cse_pkg::ChBslash);
        chars.push_back(cse_pkg::ChX);
        chars.push_back(hex_digit(beat.data_byte[7:4]));
        chars.push_back(hex_digit(beat.data_byte[3:0]));
      end
    end else begin
      if (quoted_mode_q) begin
        if (!string_open_q) begin
          chars.push_back(cse_pkg::ChQuote);
        end
        chars.push_back(cse_pkg::ChQuote);
      end
      string_open_q = 1'b0;
    end
    foreach (chars[i]) begin
      res.out_char = chars[i];
      res.last     = (i == chars.size() - 1);
      expected_chars.push_back(res);
    end
  endtask

  // Track config, predict on input beats, check output beats.
  always @(posedge clk_i) begin
    cse_pkg::out_beat_t exp_beat;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        quoted_mode_q = cfg_data;
      end
      if (in_valid && !in_stall_o) begin
        predict_escape(in_beat);
      end
      if (out_valid_o && !out_stall) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("unexpected beat: char=%h last=%b", out_beat_o.out_char,
                     out_beat_o.last);
          end
        end else begin
          exp_beat = expected_chars.pop_front();
          if (out_beat_o.out_char !== exp_beat.out_char ||
              out_beat_o.last !== exp_beat.last) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("mismatch: char exp=%h act=%h, last exp=%b act=%b",
                       exp_beat.out_char, out_beat_o.out_char,
                       exp_beat.last, out_beat_o.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid && cfg_ready_o) || (in_valid && !in_stall_o) ||
          (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("** c_string_escape_encoder: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Output side: random stall before each beat, or a long hold when requested.
  initial begin : rx_proc
    int unsigned wait_cycles;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      wait_cycles = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (rx_hold_cycles != 0) begin
        wait_cycles    = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] data);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= {kind, data};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'($urandom_range(cse_pkg::PrintLow, cse_pkg::PrintHigh));
      4:          b = 8'($urandom_range(8'h07, 8'h0d));
      5:          b = cse_pkg::ChQuote;
      6:          b = cse_pkg::ChBslash;
      default:    b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic test_quoted_directed();
    logic [7:0] bytes [$];
    bytes = '{8'h00, 8'hff, cse_pkg::ChQuote, cse_pkg::ChBslash, 8'h07, 8'h08,
              8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b, 8'h20, 8'h7e, 8'h7f, 8'h80};
    send_beat(cse_pkg::KindEnd, 8'h00);
    foreach (bytes[i]) begin
      send_beat(cse_pkg::KindData, bytes[i]);
    end
    send_beat(cse_pkg::KindEnd, 8'hff);
    wait_idle();
  endtask

  task automatic test_plain_directed();
    write_mode(1'b0);
    send_beat(cse_pkg::KindData, cse_pkg::ChQuote);
    send_beat(cse_pkg::KindData, cse_pkg::ChBslash);
    send_beat(cse_pkg::KindData, 8'h0a);
    send_beat(cse_pkg::KindEnd, 8'h00);
    send_beat(cse_pkg::KindEnd, 8'h5a);
    wait_idle();
  endtask

  task automatic test_mode_switch();
    write_mode(1'b1);
    send_beat(cse_pkg::KindData, 8'h41);
    wait_idle();
    write_mode(1'b0);
    send_beat(cse_pkg::KindData, cse_pkg::ChQuote);
    send_beat(cse_pkg::KindEnd, 8'h00);
    wait_idle();
    write_mode(1'b1);
    send_beat(cse_pkg::KindEnd, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    for (int p = 0; p < RandomPhases; p++) begin
      write_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(cse_pkg::KindEnd, 8'($urandom_range(0, 255)));
          sent++;
        end else begin
          len = $urandom_range(0, 10);
          repeat (len) begin
            send_beat(cse_pkg::KindData, pick_byte());
          end
          sent += len;
          // Leave some strings open across the next mode write.
          if ($urandom_range(0, 7) != 0) begin
            send_beat(cse_pkg::KindEnd, 8'($urandom_range(0, 255)));
            sent++;
          end
        end
      end
      wait_idle();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_mode(1'b1);
    tx_idle_on     = 1'b0;
    rx_hold_cycles = 80;
    repeat (40) begin
      send_beat(cse_pkg::KindData, 8'($urandom_range(0, 255)));
    end
    send_beat(cse_pkg::KindEnd, 8'h00);
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_quoted_directed();
    test_plain_directed();
    test_mode_switch();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    mismatches += expected_chars.size();
    if (mismatches == 0) begin
      $display("** c_string_escape_encoder: PASSED **");
    end else begin
      $display("** c_string_escape_encoder: FAILED **");
    end
    $finish;
  end

endmodule

>>> c_string_escape_encoder.f
sv/cse_pkg.sv
sv/cse_front.sv
sv/cse_queue.sv
sv/cse_back.sv
sv/c_string_escape_encoder.sv
test/tb_c_string_escape_encoder.sv
